/* sv/sirs_pkg.sv */
// Shared constants, types and symbol table lookup for the radix symbol unit.
`timescale 1ns / 1ps
`default_nettype none
package sirs_pkg;

  localparam int TABLE_SIZE       = 16;
  localparam int SYM_W            = 8;
  localparam int DIGIT_W          = 4;
  localparam int COUNT_W          = 5;
  localparam int IN_W             = 32;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_ADDR_W       = 5;
  localparam int REG_IDX_W        = 2;
  localparam int MAX_SYMBOLS_DEF  = 16;
  localparam int NUMBER_WIDTH_DEF = 32;

  localparam logic [SYM_W-1:0] MINUS_SIGN = 8'h2D;

  // Register indexes, taken from paddr[4:3]
  localparam logic [REG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_LO   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_HI   = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [CFG_DATA_W-1:0] lo,
                                               input logic [CFG_DATA_W-1:0] hi,
                                               input logic [DIGIT_W-1:0]    idx);
    logic [CFG_DATA_W-1:0] word;
    word = idx[DIGIT_W-1] ? hi : lo;
    return word[idx[DIGIT_W-2:0]*SYM_W +: SYM_W];
  endfunction

endpackage
`default_nettype wire

/* sv/sirs_cfg.sv */
// Configuration registers with an APB-style write and read port.
`timescale 1ns / 1ps
`default_nettype none
module sirs_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sirs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [sirs_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [sirs_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                    pready,
  output logic      [sirs_pkg::COUNT_W-1:0]       symbol_count,
  output logic      [sirs_pkg::CFG_DATA_W-1:0]    symbols_lo,
  output logic      [sirs_pkg::CFG_DATA_W-1:0]    symbols_hi
);

  logic [sirs_pkg::COUNT_W-1:0]    count_r;
  logic [sirs_pkg::CFG_DATA_W-1:0] lo_r;
  logic [sirs_pkg::CFG_DATA_W-1:0] hi_r;
  logic [sirs_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                            wr_en;

  assign reg_idx = paddr[sirs_pkg::CFG_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        sirs_pkg::REG_SYMBOL_COUNT: count_r <= pwdata[sirs_pkg::COUNT_W-1:0];
        sirs_pkg::REG_SYMBOLS_LO:   lo_r    <= pwdata;
        sirs_pkg::REG_SYMBOLS_HI:   hi_r    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sirs_pkg::REG_SYMBOL_COUNT:
        prdata = {{(sirs_pkg::CFG_DATA_W-sirs_pkg::COUNT_W){1'b0}}, count_r};
      sirs_pkg::REG_SYMBOLS_LO: prdata = lo_r;
      sirs_pkg::REG_SYMBOLS_HI: prdata = hi_r;
      default:                  prdata = '0;
    endcase
  end

  assign symbol_count = count_r;
  assign symbols_lo   = lo_r;
  assign symbols_hi   = hi_r;

endmodule
`default_nettype wire

/* sv/sirs_div.sv */
// Shared restoring divider: one quotient bit per cycle by the radix.
`timescale 1ns / 1ps
`default_nettype none
module sirs_div #(
  parameter int NUMBER_WIDTH = sirs_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [NUMBER_WIDTH-1:0]       dividend,
  input  wire logic [sirs_pkg::COUNT_W-1:0]  divisor,
  output logic      [NUMBER_WIDTH-1:0]       quotient,
  output logic      [sirs_pkg::DIGIT_W-1:0]  remainder,
  output sirs_pkg::div_stat_t                stat
);

  localparam int CNT_W = $clog2(NUMBER_WIDTH);

  logic [NUMBER_WIDTH-1:0]      quo_r;
  logic [sirs_pkg::DIGIT_W-1:0] rem_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [sirs_pkg::COUNT_W-1:0] trial;
  logic                         fits;

  // Remainder stays below the divisor (at most 16), so four bits hold it
  assign trial = {rem_r, quo_r[NUMBER_WIDTH-1]};
  assign fits  = (trial >= divisor);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      cnt_r <= CNT_W'(NUMBER_WIDTH - 1);
    end else if (busy_r) begin
      quo_r <= {quo_r[NUMBER_WIDTH-2:0], fits};
      rem_r <= fits ? sirs_pkg::DIGIT_W'(trial - divisor) : trial[sirs_pkg::DIGIT_W-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

/* sv/signed_integer_to_radix_symbols_unit.sv */
// Top level: renders a signed number as symbol bytes in a configured radix.
//
// Input channel in_valid/in_stall carries in_number; the low NUMBER_WIDTH bits
// are read as two's complement. Output channel out_valid/out_stall carries one
// symbol byte per transfer, most significant first, a leading minus sign for
// negative values, and out_final_symbol on the last byte of each number. A bad
// base (fewer than two symbols, too many, or a duplicate) gives one transfer
// with out_bad_base and out_final_symbol set and a zero byte.
// One item at a time: in_stall is high from the accepting edge until the last
// byte has been loaded into the output register. The sequencer checks each
// symbol in use in turn (up to 16), then divides repeatedly on the shared
// bit-serial divider, one digit per division, then emits the bytes in turn.
// While out_stall is high with a byte valid, the output register holds it and
// the sequencer waits before loading the next byte. The registers are written
// over psel/penable/pwrite at byte address 8*i and read back on prdata; pready
// is always high. Reset clears the registers and returns the sequencer to idle;
// no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module signed_integer_to_radix_symbols_unit #(
  parameter int MAX_SYMBOLS  = sirs_pkg::MAX_SYMBOLS_DEF,
  parameter int NUMBER_WIDTH = sirs_pkg::NUMBER_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [sirs_pkg::IN_W-1:0]   in_number,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [sirs_pkg::SYM_W-1:0]         out_symbol_byte,
  output logic                                    out_final_symbol,
  output logic                                    out_bad_base,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sirs_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [sirs_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [sirs_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                    pready
);

  localparam int LIMIT = (MAX_SYMBOLS < sirs_pkg::TABLE_SIZE) ? MAX_SYMBOLS
                                                              : sirs_pkg::TABLE_SIZE;
  localparam int ND_W  = $clog2(NUMBER_WIDTH + 1);
  localparam int DW    = sirs_pkg::DIGIT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_SIGN  = 6'b001000,
    S_EMIT  = 6'b010000,
    S_ERR   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [sirs_pkg::COUNT_W-1:0]    symbol_count;
  logic [sirs_pkg::CFG_DATA_W-1:0] symbols_lo;
  logic [sirs_pkg::CFG_DATA_W-1:0] symbols_hi;

  logic [DW-1:0]                   chk_idx_r, chk_idx_nxt;
  logic                            neg_r, neg_nxt;
  logic [NUMBER_WIDTH-1:0]         mag_r, mag_nxt;
  logic [NUMBER_WIDTH-1:0][DW-1:0] digits_r, digits_nxt;
  logic [ND_W-1:0]                 nd_r, nd_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [sirs_pkg::SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic                       out_fin_r, out_fin_nxt;
  logic                       out_bad_r, out_bad_nxt;

  logic                       div_start;
  logic [NUMBER_WIDTH-1:0]    div_dividend;
  logic [NUMBER_WIDTH-1:0]    div_quo;
  logic [DW-1:0]              div_rem;
  sirs_pkg::div_stat_t        div_stat;

  logic                       accept;
  logic                       out_free;
  logic [NUMBER_WIDTH-1:0]    raw;
  logic                       range_bad;
  logic                       dup;
  logic [sirs_pkg::SYM_W-1:0] sym_i;

  sirs_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .symbol_count (symbol_count),
    .symbols_lo   (symbols_lo),
    .symbols_hi   (symbols_hi)
  );

  sirs_div #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (symbol_count),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign raw      = in_number[NUMBER_WIDTH-1:0];

  assign range_bad = (symbol_count < sirs_pkg::COUNT_W'(2)) ||
                     (symbol_count > sirs_pkg::COUNT_W'(LIMIT));
  assign sym_i     = sirs_pkg::sym_at(symbols_lo, symbols_hi, chk_idx_r);

  // Compare the current symbol against every later symbol in use
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < sirs_pkg::TABLE_SIZE; j++) begin
      if ((DW'(j) > chk_idx_r) && (sirs_pkg::COUNT_W'(j) < symbol_count) &&
          (sirs_pkg::sym_at(symbols_lo, symbols_hi, DW'(j)) == sym_i)) begin
        dup = 1'b1;
      end
    end
  end

  assign div_dividend = (state_r == S_DIV) ? div_quo : mag_r;

  always_comb begin
    state_nxt     = state_r;
    chk_idx_nxt   = chk_idx_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    digits_nxt    = digits_r;
    nd_nxt        = nd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_sym_nxt   = out_sym_r;
    out_fin_nxt   = out_fin_r;
    out_bad_nxt   = out_bad_r;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_nxt     = raw[NUMBER_WIDTH-1];
          mag_nxt     = raw[NUMBER_WIDTH-1] ? (~raw + 1'b1) : raw;
          chk_idx_nxt = '0;
          nd_nxt      = '0;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (range_bad || dup) begin
          state_nxt = S_ERR;
        end else if (chk_idx_r == DW'(symbol_count - 1'b1)) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          chk_idx_nxt = chk_idx_r + 1'b1;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          // Push the digit; the stack pops in reverse order
          digits_nxt = {digits_r[NUMBER_WIDTH-2:0], div_rem};
          nd_nxt     = nd_r + 1'b1;
          if ((div_quo == '0) || (nd_r == ND_W'(NUMBER_WIDTH - 1))) begin
            state_nxt = neg_r ? S_SIGN : S_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = sirs_pkg::MINUS_SIGN;
          out_fin_nxt   = 1'b0;
          out_bad_nxt   = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = sirs_pkg::sym_at(symbols_lo, symbols_hi, digits_r[0]);
          out_fin_nxt   = (nd_r == ND_W'(1));
          out_bad_nxt   = 1'b0;
          digits_nxt    = {DW'(0), digits_r[NUMBER_WIDTH-1:1]};
          nd_nxt        = nd_r - 1'b1;
          if (nd_r == ND_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = '0;
          out_fin_nxt   = 1'b1;
          out_bad_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      nd_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nd_r        <= nd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    neg_r     <= neg_nxt;
    mag_r     <= mag_nxt;
    digits_r  <= digits_nxt;
    out_sym_r <= out_sym_nxt;
    out_fin_r <= out_fin_nxt;
    out_bad_r <= out_bad_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_symbol_byte  = out_sym_r;
  assign out_final_symbol = out_fin_r;
  assign out_bad_base     = out_bad_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input taken again right after a transfer");

  a_bad_base_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_base) |-> (out_final_symbol && (out_symbol_byte == '0)))
    else $error("bad base result not marked final with zero byte");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    nd_r <= ND_W'(NUMBER_WIDTH))
    else $error("digit stack overflow");

endmodule
`default_nettype wire
